// ===== rtl/mhq_pkg.sv =====
// ---------------------------------------------------------------------------
// mhq_pkg: shared types and constants
// Codes and state encoding for the monotone hull max query block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhq_pkg;

  // fixed port widths
  localparam int unsigned InWidth  = 32;
  localparam int unsigned ValWidth = 64;
  localparam int unsigned StWidth  = 2;

  // request opcodes
  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  // result status codes
  localparam logic [StWidth-1:0] StatusOk    = 2'd0;
  localparam logic [StWidth-1:0] StatusEmpty = 2'd1;
  localparam logic [StWidth-1:0] StatusFull  = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SEL,
    S_ADD_CHK,
    S_ADD_MUL,
    S_ADD_CMP,
    S_ADD_PUSH,
    S_Q_SEL,
    S_Q_MUL,
    S_Q_CMP,
    S_Q_FMUL,
    S_Q_SUM
  } state_e;

endpackage

// ===== rtl/mhq_ram.sv =====
// ---------------------------------------------------------------------------
// mhq_ram: generic single port ram
// One write or one read per cycle, read data registered and held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/monotone_hull_max_query_top.sv =====
// ---------------------------------------------------------------------------
// monotone_hull_max_query_top: upper envelope of lines with max queries
// Deque of lines in one ram, walked by a sequencer with exact breakpoints.
// ---------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its single
// result appears on value_o/status_o for one cycle with valid_o, and the
// receiver cannot hold it off. An add reads and checks back lines in turn
// (S_ADD_SEL, S_ADD_CHK), tests breakpoints (S_ADD_MUL, S_ADD_CMP) and ends
// with the push or the full flag (S_ADD_PUSH); a discarded add ends after its
// check with no push. A query on a non-empty hull drops front lines while the
// next breakpoint is at or below the point (S_Q_SEL, S_Q_MUL, S_Q_CMP), then
// forms the value (S_Q_FMUL, S_Q_SUM); an empty query answers in the next
// cycle without raising busy_o. busy_o drops in the cycle the result is shown,
// so the next request can be taken then. Each line visited needs one read of
// the single ram port, and a breakpoint test adds a multiply and a compare.
`timescale 1ns / 1ps

module monotone_hull_max_query_top #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                op_i,
  input  logic signed [mhq_pkg::InWidth-1:0]  slope_i,
  input  logic signed [mhq_pkg::InWidth-1:0]  intercept_i,
  input  logic signed [mhq_pkg::InWidth-1:0]  point_i,
  output logic                                valid_o,
  output logic signed [mhq_pkg::ValWidth-1:0] value_o,
  output logic [mhq_pkg::StWidth-1:0]         status_o
);

  localparam int unsigned CW   = COEF_WIDTH;
  localparam int unsigned NW   = CW + 2;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned PW   = NW + DW + 1;
  localparam int unsigned EW   = 2 * CW + NW + DW;
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned VW   = mhq_pkg::ValWidth;

  mhq_pkg::state_e state_q, state_d;

  logic signed [CW-1:0]  a_q, a_d, b_q, b_d, x_q, x_d;
  logic [CNTW-1:0]       t_q, t_d, count_q, count_d;
  logic [AW-1:0]         front_q, front_d;
  logic signed [NW-1:0]  num_q, num_d;
  logic [DW-1:0]         den_q, den_d;
  logic signed [PW-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic                  valid_q, valid_d;
  logic signed [VW-1:0]  value_q, value_d;
  logic [mhq_pkg::StWidth-1:0] status_q, status_d;

  // ram port
  logic          we, re;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [CNTW-1:0] offs;
  logic [CNTW:0]   sum;

  // fields of the entry read back
  logic signed [CW-1:0] ab, bb;
  logic signed [NW-1:0] bnum;
  logic [DW-1:0]        bden;
  logic signed [CW:0]   diff;
  logic signed [NW-1:0] nraw;

  assign ab   = $signed(rdata[EW-1 -: CW]);
  assign bb   = $signed(rdata[EW-CW-1 -: CW]);
  assign bnum = $signed(rdata[DW +: NW]);
  assign bden = rdata[DW-1:0];
  assign diff = (CW+1)'(a_q) - (CW+1)'(ab);
  assign nraw = NW'(bb) - NW'(b_q);

  // circular slot of the deque: front plus offset, wrapped
  always_comb begin
    sum = {1'b0, (CNTW)'(front_q)} + {1'b0, offs};
    if (sum >= (CNTW+1)'(DEPTH)) begin
      sum = sum - (CNTW+1)'(DEPTH);
    end
    addr = sum[AW-1:0];
  end

  mhq_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhq_pkg::S_IDLE;
      count_q <= '0;
      front_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      front_q <= front_d;
      valid_q <= valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    x_q      <= x_d;
    t_q      <= t_d;
    num_q    <= num_d;
    den_q    <= den_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    front_d  = front_q;
    valid_d  = 1'b0;
    a_d      = a_q;
    b_d      = b_q;
    x_d      = x_q;
    t_d      = t_q;
    num_d    = num_q;
    den_d    = den_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    value_d  = value_q;
    status_d = status_q;
    we       = 1'b0;
    re       = 1'b0;
    offs     = '0;
    wdata    = {a_q, b_q, num_q, den_q};

    unique case (state_q)
      mhq_pkg::S_IDLE: begin
        if (start_i) begin
          a_d      = $signed(slope_i[CW-1:0]);
          b_d      = $signed(intercept_i[CW-1:0]);
          x_d      = $signed(point_i[CW-1:0]);
          t_d      = count_q;
          value_d  = '0;
          status_d = mhq_pkg::StatusOk;
          if (op_i == mhq_pkg::OpAdd) begin
            state_d = mhq_pkg::S_ADD_SEL;
          end else if (count_q == '0) begin
            status_d = mhq_pkg::StatusEmpty;
            valid_d  = 1'b1;
          end else begin
            state_d = mhq_pkg::S_Q_SEL;
          end
        end
      end

      // read back line, or push when the deque is exhausted
      mhq_pkg::S_ADD_SEL: begin
        if (t_q == '0) begin
          state_d = mhq_pkg::S_ADD_PUSH;
        end else begin
          offs    = t_q - 1'b1;
          re      = 1'b1;
          state_d = mhq_pkg::S_ADD_CHK;
        end
      end

      // equal slope handling and new breakpoint
      mhq_pkg::S_ADD_CHK: begin
        if (diff == '0) begin
          if (b_q <= bb) begin
            valid_d = 1'b1;
            state_d = mhq_pkg::S_IDLE;
          end else begin
            t_d     = t_q - 1'b1;
            state_d = mhq_pkg::S_ADD_SEL;
          end
        end else begin
          if (diff < 0) begin
            num_d = -nraw;
            den_d = DW'(-diff);
          end else begin
            num_d = nraw;
            den_d = DW'(diff);
          end
          state_d = (t_q >= CNTW'(2)) ? mhq_pkg::S_ADD_MUL : mhq_pkg::S_ADD_PUSH;
        end
      end

      // cross products of the two breakpoints
      mhq_pkg::S_ADD_MUL: begin
        pa_d    = PW'(num_q) * PW'($signed({1'b0, bden}));
        pb_d    = PW'(bnum) * PW'($signed({1'b0, den_q}));
        state_d = mhq_pkg::S_ADD_CMP;
      end

      mhq_pkg::S_ADD_CMP: begin
        if (pa_q < pb_q) begin
          t_d     = t_q - 1'b1;
          state_d = mhq_pkg::S_ADD_SEL;
        end else begin
          state_d = mhq_pkg::S_ADD_PUSH;
        end
      end

      // write the new line behind the kept ones, or flag a full store
      mhq_pkg::S_ADD_PUSH: begin
        offs    = t_q;
        valid_d = 1'b1;
        state_d = mhq_pkg::S_IDLE;
        if (t_q == CNTW'(DEPTH)) begin
          status_d = mhq_pkg::StatusFull;
        end else begin
          if (t_q == '0) begin
            wdata = {a_q, b_q, NW'(0), DW'(1)};
          end
          we      = 1'b1;
          count_d = t_q + 1'b1;
        end
      end

      // read second line, or front line when alone
      mhq_pkg::S_Q_SEL: begin
        re = 1'b1;
        if (count_q > CNTW'(1)) begin
          offs    = CNTW'(1);
          state_d = mhq_pkg::S_Q_MUL;
        end else begin
          state_d = mhq_pkg::S_Q_FMUL;
        end
      end

      mhq_pkg::S_Q_MUL: begin
        pa_d    = PW'(x_q) * PW'($signed({1'b0, bden}));
        state_d = mhq_pkg::S_Q_CMP;
      end

      // drop the front when the next breakpoint is at or below the point
      mhq_pkg::S_Q_CMP: begin
        offs = CNTW'(1);
        if (PW'(bnum) <= pa_q) begin
          front_d = addr;
          count_d = count_q - 1'b1;
          state_d = mhq_pkg::S_Q_SEL;
        end else begin
          re      = 1'b1;
          offs    = '0;
          state_d = mhq_pkg::S_Q_FMUL;
        end
      end

      mhq_pkg::S_Q_FMUL: begin
        pa_d    = PW'(ab) * PW'(x_q);
        pb_d    = PW'(bb);
        state_d = mhq_pkg::S_Q_SUM;
      end

      mhq_pkg::S_Q_SUM: begin
        value_d = VW'(pa_q) + VW'(pb_q);
        valid_d = 1'b1;
        state_d = mhq_pkg::S_IDLE;
      end

      default: state_d = mhq_pkg::S_IDLE;
    endcase
  end

  assign busy_o   = (state_q != mhq_pkg::S_IDLE);
  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign status_o = status_q;

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(DEPTH)) else $error("line count above depth");

  a_status_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == mhq_pkg::StatusOk || status_o == mhq_pkg::StatusEmpty ||
                 status_o == mhq_pkg::StatusFull))
    else $error("unknown status code on result");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result shown while busy");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != mhq_pkg::StatusOk) |-> (value_o == '0))
    else $error("flagged result with nonzero value");

endmodule

// ===== bench/monotone_hull_max_query_top_tb.sv =====
// ---------------------------------------------------------------------------
// monotone_hull_max_query_top_tb: self-checking bench for the hull block
// Drives add and query requests through the start/busy handshake, predicts
// each result with a behavioral deque of lines and checks every strobed result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module monotone_hull_max_query_top_tb;

  localparam int unsigned Depth    = 1024;
  localparam int unsigned Tangents = 200;

  typedef struct {
    logic        op;
    logic [31:0] slope;
    logic [31:0] icpt;
    logic [31:0] point;
    int unsigned gap_pct;
  } hull_req_t;

  typedef struct {
    logic signed [63:0] value;
    logic [1:0]         status;
  } hull_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        op_i = mhq_pkg::OpAdd;
  logic signed [31:0] slope_i = '0;
  logic signed [31:0] intercept_i = '0;
  logic signed [31:0] point_i = '0;
  logic        valid_o;
  logic signed [63:0] value_o;
  logic [1:0]  status_o;

  monotone_hull_max_query_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .op_i(op_i), .slope_i(slope_i), .intercept_i(intercept_i),
    .point_i(point_i), .valid_o(valid_o), .value_o(value_o),
    .status_o(status_o)
  );

  // envelope model state
  longint      env_slope [Depth];
  longint      env_icpt  [Depth];
  longint      env_num   [Depth];
  longint      env_den   [Depth];
  int unsigned env_front = 0;
  int unsigned env_count = 0;

  hull_req_t   pending_reqs[$];
  hull_res_t   expected_results[$];
  int          mismatches = 0;
  int          n_adds = 0, n_queries = 0, n_full = 0, n_empty = 0;

  // slot of the i-th kept line
  function automatic int unsigned env_slot(int unsigned i);
    return (env_front + i) % Depth;
  endfunction

  // exact n1/d1 < n2/d2 with positive denominators
  function automatic bit frac_below(longint n1, longint d1, longint n2, longint d2);
    logic signed [69:0] p1, p2, w;
    p1 = n1; w = d2; p1 = p1 * w;
    p2 = n2; w = d1; p2 = p2 * w;
    return p1 < p2;
  endfunction

  // apply one request to the envelope and return its result
  function automatic hull_res_t envelope_step(hull_req_t r);
    hull_res_t     res;
    longint        a, b, ab, bb, d, num, den, x;
    logic signed [69:0] lhs, rhs;
    int unsigned   t, k;
    bit            discard;
    res.value = 0;
    res.status = mhq_pkg::StatusOk;
    if (r.op == mhq_pkg::OpAdd) begin
      a = $signed(r.slope);
      b = $signed(r.icpt);
      t = env_count;
      num = 0;
      den = 1;
      discard = 0;
      while (t > 0) begin
        k = env_slot(t - 1);
        ab = env_slope[k];
        bb = env_icpt[k];
        if (a == ab) begin
          if (b <= bb) begin
            discard = 1;
            break;
          end
          t--;
          continue;
        end
        d = a - ab;
        num = bb - b;
        if (d < 0) begin
          d = -d;
          num = -num;
        end
        den = d;
        // new breakpoint strictly below the back line's breakpoint
        if (t >= 2 && frac_below(num, den, env_num[k], env_den[k])) t--;
        else break;
      end
      if (t == 0) begin
        num = 0;
        den = 1;
      end
      if (!discard) begin
        if (t >= Depth) begin
          res.status = mhq_pkg::StatusFull;
        end else begin
          k = env_slot(t);
          env_count = t + 1;
          env_slope[k] = a;
          env_icpt[k] = b;
          env_num[k] = num;
          env_den[k] = den;
        end
      end
    end else begin
      x = $signed(r.point);
      if (env_count == 0) begin
        res.status = mhq_pkg::StatusEmpty;
      end else begin
        // drop front lines overtaken at or below the point
        while (env_count > 1) begin
          k = env_slot(1);
          lhs = env_num[k];
          rhs = x;
          rhs = rhs * env_den[k];
          if (lhs <= rhs) begin
            env_front = k;
            env_count--;
          end else begin
            break;
          end
        end
        res.value = env_slope[env_front] * x + env_icpt[env_front];
      end
    end
    return res;
  endfunction

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i) begin
    hull_req_t r;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        r = pending_reqs[0];
        pending_reqs.delete(0);
        expected_results = {expected_results, envelope_step(r)};
        if (r.op == mhq_pkg::OpAdd) n_adds++;
        else n_queries++;
      end
      if (!(start_i && busy_o)) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(99) >= pending_reqs[0].gap_pct) begin
          start_i     <= 1'b1;
          op_i        <= pending_reqs[0].op;
          slope_i     <= pending_reqs[0].slope;
          intercept_i <= pending_reqs[0].icpt;
          point_i     <= pending_reqs[0].point;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    hull_res_t e;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", value_o, status_o);
        mismatches++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (value_o !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, value_o);
          mismatches++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          mismatches++;
        end
        if (e.status == mhq_pkg::StatusFull) n_full++;
        if (e.status == mhq_pkg::StatusEmpty) n_empty++;
      end
    end
  end

  task automatic queue_req(logic op, logic [31:0] s, logic [31:0] c, logic [31:0] p,
                           int unsigned gap);
    hull_req_t r;
    r.op = op;
    r.slope = s;
    r.icpt = c;
    r.point = p;
    r.gap_pct = gap;
    pending_reqs = {pending_reqs, r};
  endtask

  // stimulus and end of run
  initial begin
    longint      s_cur, p_cur;
    int unsigned gap, len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queries at both extremes
    queue_req(mhq_pkg::OpQuery, $urandom, $urandom, 32'h8000_0000, 14);
    queue_req(mhq_pkg::OpQuery, $urandom, $urandom, 32'h7fff_ffff, 14);
    // tangent lines all stay on the envelope, building a deep deque
    for (int k = 0; k < Tangents; k++)
      queue_req(mhq_pkg::OpAdd, k, -(k * k), 0, 14);
    queue_req(mhq_pkg::OpQuery, 0, 0, 32'h8000_0000, 14);
    queue_req(mhq_pkg::OpQuery, 0, 0, 500, 14);
    // equal slope: lower intercept discarded, higher replaces back line
    queue_req(mhq_pkg::OpAdd, Tangents - 1, -(Tangents - 1) * (Tangents - 1) - 1, 0, 14);
    queue_req(mhq_pkg::OpAdd, Tangents - 1, 32'h7fff_ffff, 0, 14);
    queue_req(mhq_pkg::OpAdd, 32'h7fff_ffff, 32'h8000_0000, 0, 14);
    queue_req(mhq_pkg::OpAdd, 32'h7fff_ffff, 32'h7fff_ffff, 0, 14);
    queue_req(mhq_pkg::OpQuery, 0, 0, 32'h7fff_ffff, 14);
    // decreasing slope and point
    queue_req(mhq_pkg::OpAdd, 32'h8000_0000, 32'h8000_0000, 0, 14);
    queue_req(mhq_pkg::OpQuery, 0, 0, 32'h8000_0000, 14);

    // random well-formed runs with some noise, three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      gap = (ph == 0) ? 14 : (ph == 1) ? 61 : 0;
      for (int n = 0; n < 160; n += len) begin
        len = $urandom_range(40, 8);
        s_cur = $signed($urandom_range(2000)) - 1000;
        p_cur = $signed($urandom_range(20000)) - 10000;
        if ($urandom_range(3) == 0) begin
          s_cur = $signed($urandom);
          p_cur = $signed($urandom);
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            queue_req(1'($urandom_range(1)), $urandom, $urandom, $urandom, gap);
          end else if ($urandom_range(1) == 0) begin
            if (s_cur < 64'sd2147483632)
              s_cur += $urandom_range(3) == 0 ? 0 : $urandom_range(50);
            queue_req(mhq_pkg::OpAdd, 32'(s_cur),
                      $signed($urandom_range(200000)) - 100000, $urandom, gap);
          end else begin
            if (p_cur < 64'sd2147418112) p_cur += $urandom_range(300);
            queue_req(mhq_pkg::OpQuery, $urandom, $urandom, 32'(p_cur), gap);
          end
        end
      end
    end

    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d adds and %0d queries", n_adds, n_queries);
    $display("results with store full: %0d, with empty hull: %0d", n_full, n_empty);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mhq_pkg.sv
rtl/mhq_ram.sv
rtl/monotone_hull_max_query_top.sv
bench/monotone_hull_max_query_top_tb.sv
